// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RPCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rpct_pkg.sv
// ----------------------------------------------------------------------------
// rpct_pkg
// Types, widths and codes of the relay pending command tracker.
// ----------------------------------------------------------------------------
package rpct_pkg;

  localparam int TableDepth = 8;
  localparam int IdBits     = 16;
  localparam int PtrW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);

  localparam int ActW    = 3;
  localparam int CmdIdW  = 16;
  localparam int DurW    = 31;
  localparam int TimeW   = 48;
  localparam int MarginW = 16;
  localparam int RemW    = 32;
  localparam int CfgIdxW = 1;
  localparam int CfgDatW = 16;

  localparam logic [MarginW-1:0] MarginReset = 16'd3000;

  // input action codes
  typedef enum logic [ActW-1:0] {
    ACT_TIMED   = 3'd0,
    ACT_DEFAULT = 3'd1,
    ACT_SUCCESS = 3'd2,
    ACT_FAILURE = 3'd3,
    ACT_POLL    = 3'd4
  } action_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MARGIN   = 1'b0,
    CFG_POWER_ON = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              timed;
    logic              state;
    logic [IdBits-1:0] id;
    logic [DurW-1:0]   duration;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic append;
    logic apply;
    logic sum;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic            scan_done;
    logic [CntW-1:0] count;
  } dp_sts_t;

endpackage

// File: rtl/core/rpct_if.sv
// ----------------------------------------------------------------------------
// rpct interfaces
// Valid/ready channels for command items, result items and register writes.
// ----------------------------------------------------------------------------
interface rpct_item_if;
  import rpct_pkg::*;
  logic               valid;
  logic               ready;
  logic [ActW-1:0]    action;
  logic [CmdIdW-1:0]  command_id;
  logic               wanted_state;
  logic [DurW-1:0]    duration_ms;
  logic [TimeW-1:0]   now_ms;

  modport source (output valid, action, command_id, wanted_state, duration_ms, now_ms,
                  input ready);
  modport sink   (input valid, action, command_id, wanted_state, duration_ms, now_ms,
                  output ready);
endinterface

interface rpct_result_if;
  import rpct_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   relay_on;
  logic                   shown_request;
  logic signed [RemW-1:0] remaining_ms;
  logic                   matched;
  logic                   queue_full;

  modport source (output valid, relay_on, shown_request, remaining_ms, matched, queue_full,
                  input ready);
  modport sink   (input valid, relay_on, shown_request, remaining_ms, matched, queue_full,
                  output ready);
endinterface

interface rpct_cfg_if;
  import rpct_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/rpct_ctrl.sv
// ----------------------------------------------------------------------------
// rpct_ctrl
// Sequencer: accept, table scan, append, apply, end-time sum, result load.
// ----------------------------------------------------------------------------
module rpct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rpct_pkg::dp_sts_t sts_i,
  output rpct_pkg::dp_cmd_t cmd_o
);
  import rpct_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_APPEND = 6'b000100,
    S_APPLY  = 6'b001000,
    S_SUM    = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = S_APPEND;
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/rpct_dp.sv
// ----------------------------------------------------------------------------
// rpct_dp
// Pending table with in-place compaction, override timer and result register.
// ----------------------------------------------------------------------------
module rpct_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rpct_pkg::dp_cmd_t               cmd_i,
  output rpct_pkg::dp_sts_t               sts_o,
  input  logic [rpct_pkg::ActW-1:0]       action_i,
  input  logic [rpct_pkg::CmdIdW-1:0]     command_id_i,
  input  logic                            wanted_state_i,
  input  logic [rpct_pkg::DurW-1:0]       duration_ms_i,
  input  logic [rpct_pkg::TimeW-1:0]      now_ms_i,
  input  logic                            cfg_we_i,
  input  logic [rpct_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rpct_pkg::CfgDatW-1:0]    cfg_data_i,
  output logic                            relay_on_o,
  output logic                            shown_request_o,
  output logic signed [rpct_pkg::RemW-1:0] remaining_ms_o,
  output logic                            matched_o,
  output logic                            queue_full_o
);
  import rpct_pkg::*;

  // table and scan pointers
  entry_t          tab_q [TableDepth];
  logic [CntW-1:0] count_q, rd_q, wr_q;

  // latched item
  action_e           act_q;
  logic [IdBits-1:0] id_q;
  logic              want_q;
  logic [DurW-1:0]   dur_q;
  logic [TimeW-1:0]  now_q;

  // per-item flags
  logic   hit_q, matched_q, full_q, shown_vld_q, shown_st_q;
  entry_t hit_ent_q;

  // registers and override state
  logic [MarginW-1:0]     margin_q;
  logic                   default_q;
  logic                   ovr_state_q;
  logic signed [RemW-1:0] ovr_len_q;
  logic [TimeW-1:0]       ovr_start_q;
  logic [TimeW:0]         end_q;
  logic                   len_pos_q;

  // result register
  logic                   res_relay_q, res_shown_q, res_matched_q, res_full_q;
  logic signed [RemW-1:0] res_rem_q;

  logic            scan_done, is_queue, id_eq, drop, keep_step, tab_full;
  entry_t          cur, new_ent;
  logic [TimeW+1:0] diff;
  logic            diff_neg, relay;
  logic [RemW-1:0] rem;

  assign scan_done = (rd_q == count_q);
  assign cur       = tab_q[rd_q[PtrW-1:0]];
  assign id_eq     = (cur.id == id_q);
  assign is_queue  = (act_q == ACT_TIMED) || (act_q == ACT_DEFAULT);
  assign drop      = id_eq && (((act_q == ACT_SUCCESS) && !hit_q) || (act_q == ACT_FAILURE));
  assign keep_step = cmd_i.scan && !scan_done && !drop;
  assign tab_full  = (wr_q >= CntW'(TableDepth));

  assign new_ent.timed    = (act_q == ACT_TIMED);
  assign new_ent.state    = want_q;
  assign new_ent.id       = id_q;
  assign new_ent.duration = (act_q == ACT_TIMED) ? dur_q : '0;

  assign sts_o.scan_done = scan_done;
  assign sts_o.count     = count_q;

  // table storage, compacted as the scan goes
  always_ff @(posedge clk_i) begin
    if (keep_step) begin
      tab_q[wr_q[PtrW-1:0]] <= cur;
    end else if (cmd_i.append && is_queue && !tab_full) begin
      tab_q[wr_q[PtrW-1:0]] <= new_ent;
    end
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_e'(action_i);
      id_q   <= command_id_i[IdBits-1:0];
      want_q <= wanted_state_i;
      dur_q  <= duration_ms_i;
      now_q  <= now_ms_i;
    end
    if (cmd_i.scan && !scan_done && drop && (act_q == ACT_SUCCESS)) hit_ent_q <= cur;
  end

  // scan, append and flag control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      hit_q       <= 1'b0;
      matched_q   <= 1'b0;
      full_q      <= 1'b0;
      shown_vld_q <= 1'b0;
      shown_st_q  <= 1'b0;
    end else if (cmd_i.load) begin
      rd_q        <= '0;
      wr_q        <= '0;
      hit_q       <= 1'b0;
      matched_q   <= 1'b0;
      full_q      <= 1'b0;
      shown_vld_q <= 1'b0;
    end else if (cmd_i.scan && !scan_done) begin
      rd_q <= rd_q + 1'b1;
      if (drop) begin
        matched_q <= 1'b1;
        if (act_q == ACT_SUCCESS) hit_q <= 1'b1;
      end else begin
        wr_q <= wr_q + 1'b1;
        if (cur.timed) begin
          shown_vld_q <= 1'b1;
          shown_st_q  <= cur.state;
        end
      end
    end else if (cmd_i.append) begin
      if (is_queue && tab_full) begin
        full_q  <= 1'b1;
        count_q <= wr_q;
      end else if (is_queue) begin
        count_q <= wr_q + 1'b1;
        if (new_ent.timed) begin
          shown_vld_q <= 1'b1;
          shown_st_q  <= want_q;
        end
      end else begin
        count_q <= wr_q;
      end
    end
  end

  // override state, default state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q    <= MarginReset;
      default_q   <= 1'b0;
      ovr_state_q <= 1'b0;
      ovr_len_q   <= '0;
      ovr_start_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_MARGIN)) margin_q <= cfg_data_i[MarginW-1:0];
      if (cfg_we_i && (cfg_index_i == CFG_POWER_ON)) default_q <= cfg_data_i[0];
      if (cmd_i.apply && hit_q) begin
        if (hit_ent_q.timed) begin
          ovr_start_q <= now_q;
          ovr_state_q <= hit_ent_q.state;
          ovr_len_q   <= $signed({1'b0, hit_ent_q.duration}) -
                         $signed({{(RemW-MarginW){1'b0}}, margin_q});
        end else begin
          default_q <= hit_ent_q.state;
        end
      end
    end
  end

  // override end time
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      end_q     <= {1'b0, ovr_start_q} + {{(TimeW+1-DurW){1'b0}}, ovr_len_q[DurW-1:0]};
      len_pos_q <= !ovr_len_q[RemW-1] && (ovr_len_q != '0);
    end
  end

  // time left, clamped
  always_comb begin
    diff     = {1'b0, end_q} - {2'b0, now_q};
    diff_neg = diff[TimeW+1];
    relay    = (len_pos_q && !diff_neg) ? ovr_state_q : default_q;
    if (!len_pos_q) begin
      rem = '1;
    end else if (diff_neg) begin
      rem = '0;
    end else if (diff[TimeW:RemW-1] != '0) begin
      rem = {1'b0, {(RemW-1){1'b1}}};
    end else begin
      rem = {1'b0, diff[RemW-2:0]};
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_relay_q   <= relay;
      res_shown_q   <= shown_vld_q ? shown_st_q : relay;
      res_rem_q     <= $signed(rem);
      res_matched_q <= matched_q;
      res_full_q    <= full_q;
    end
  end

  assign relay_on_o      = res_relay_q;
  assign shown_request_o = res_shown_q;
  assign remaining_ms_o  = res_rem_q;
  assign matched_o       = res_matched_q;
  assign queue_full_o    = res_full_q;

endmodule

// File: rtl/core/relay_pending_command_tracker.sv
// ----------------------------------------------------------------------------
// relay_pending_command_tracker
// Ordered table of relay commands awaiting acknowledgement, with timed override.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  in_i     | in  | action, command_id, wanted_state, duration_ms, now_ms
//  out_o    | out | relay_on, shown_request, remaining_ms, matched, queue_full
//  cfg_i    | in  | index (0 margin, 1 power-on state), data
//
//  A transaction is loaded, then the table scan moves one entry per cycle,
//  then append, apply, end-time sum and result load follow in that order.
//  Reset empties the table, loads margin 3000 and default state 0 at once.
//  A result waits in the output register while the next transaction is taken;
//  the block stalls only at the result load while that register is still full.
//  Register writes are taken every cycle.
`include "assert_macros.svh"

module relay_pending_command_tracker (
  input logic            clk_i,
  input logic            rst_ni,
  rpct_item_if.sink      in_i,
  rpct_result_if.source  out_o,
  rpct_cfg_if.sink       cfg_i
);
  import rpct_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_i.ready = 1'b1;

  // sequencer
  rpct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // table and timer datapath
  rpct_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (in_i.action),
    .command_id_i    (in_i.command_id),
    .wanted_state_i  (in_i.wanted_state),
    .duration_ms_i   (in_i.duration_ms),
    .now_ms_i        (in_i.now_ms),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .relay_on_o      (out_o.relay_on),
    .shown_request_o (out_o.shown_request),
    .remaining_ms_o  (out_o.remaining_ms),
    .matched_o       (out_o.matched),
    .queue_full_o    (out_o.queue_full)
  );

  // table never holds more than its depth
  `RPCT_ASSERT_IMPL(a_count_bound, 1'b1, sts.count <= CntW'(TableDepth), "count overflow")
  // an accepted transaction keeps the input closed in the next cycle
  `RPCT_ASSERT_NEXT(a_busy_after_load, in_i.valid && in_i.ready, !in_i.ready, "ready too early")
  // a negative time left is only the no-override code
  `RPCT_ASSERT_IMPL(a_rem_code, out_o.valid && out_o.remaining_ms[RemW-1],
                    out_o.remaining_ms == '1, "bad negative remaining")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the relay pending command tracker: a directed
// table of commands and acknowledgements, then random command traffic over
// several margin and power-on settings, each result compared with a fixed
// expected status or with a bit-exact status predictor.
// ----------------------------------------------------------------------------
module tb;
  import rpct_pkg::*;

  localparam int                TblRows       = 25;
  localparam int                NumPhases     = 5;
  localparam int                ItemsPerPhase = 305;
  localparam int                WatchLimit    = 2000;
  localparam int                HoldCycles    = 400;
  localparam logic [ActW-1:0]   ActUnknown    = 3'd7;
  localparam longint unsigned   RemMax        = 64'd2147483647;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [CmdIdW-1:0] id;
    logic              wanted;
    logic [DurW-1:0]   dur;
    logic [TimeW-1:0]  now;
  } relay_cmd_t;

  typedef struct packed {
    logic                   relay_on;
    logic                   shown;
    logic signed [RemW-1:0] remaining;
    logic                   matched;
    logic                   full;
  } relay_status_t;

  typedef struct packed {
    relay_cmd_t    cmd;
    logic          fixed;
    relay_status_t status;
  } cmd_row_t;

  logic clk_i;
  logic rst_ni;

  rpct_item_if   cmd_if ();
  rpct_result_if res_if ();
  rpct_cfg_if    cfg_if ();

  relay_pending_command_tracker i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // predictor state, mirrors the block after every accepted transaction
  entry_t            pend_tbl [TableDepth];
  int                pend_cnt      = 0;
  logic [MarginW-1:0] margin_q     = MarginReset;
  logic              default_q     = 1'b0;
  logic              ovr_state_q   = 1'b0;
  longint            ovr_len_q     = 0;
  logic [TimeW-1:0]  ovr_start_q   = '0;

  relay_status_t     status_q [$];
  int                mismatch_cnt  = 0;
  int                quiet_cycles  = 0;
  int                hold_len      = 0;
  bit                idle_on       = 1'b1;
  logic [TimeW-1:0]  wall_ms       = '0;
  logic [CmdIdW-1:0] id_pool [4];
  cmd_row_t          cmd_tbl [TblRows];

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_cnt++;
  endtask

  // remove one table entry, keeping the order of the rest
  function automatic void drop_pending(input int pos);
    for (int k = pos; k + 1 < pend_cnt; k++) pend_tbl[k] = pend_tbl[k + 1];
    pend_cnt--;
  endfunction

  // status after one command, updating the predictor state
  function automatic relay_status_t predict_relay_status(input relay_cmd_t c);
    relay_status_t    r;
    entry_t           hit;
    longint unsigned  end_ms;
    longint unsigned  left_ms;
    bit               found;
    int               k;
    r = '0;
    found = 1'b0;
    case (c.action)
      ACT_TIMED, ACT_DEFAULT: begin
        if (pend_cnt >= TableDepth) begin
          r.full = 1'b1;
        end else begin
          pend_tbl[pend_cnt] = '{timed: (c.action == ACT_TIMED), state: c.wanted, id: c.id,
                                 duration: (c.action == ACT_TIMED) ? c.dur : '0};
          pend_cnt++;
        end
      end
      ACT_SUCCESS: begin
        // oldest entry with this id is applied
        for (k = 0; k < pend_cnt && !found; k++) begin
          if (pend_tbl[k].id == c.id) begin
            found = 1'b1;
            hit = pend_tbl[k];
            if (hit.timed) begin
              ovr_start_q = c.now;
              ovr_state_q = hit.state;
              ovr_len_q   = longint'(hit.duration) - longint'(margin_q);
            end else begin
              default_q = hit.state;
            end
            drop_pending(k);
          end
        end
        r.matched = found;
      end
      ACT_FAILURE: begin
        // every entry with this id goes
        k = 0;
        while (k < pend_cnt) begin
          if (pend_tbl[k].id == c.id) begin
            r.matched = 1'b1;
            drop_pending(k);
          end else begin
            k++;
          end
        end
      end
      default: ;
    endcase

    if (ovr_len_q > 0) begin
      end_ms = 64'(ovr_start_q) + 64'(ovr_len_q);
      if (64'(c.now) > end_ms) begin
        r.relay_on  = default_q;
        r.remaining = '0;
      end else begin
        r.relay_on  = ovr_state_q;
        left_ms     = end_ms - 64'(c.now);
        r.remaining = (left_ms > RemMax) ? RemW'(RemMax) : RemW'(left_ms);
      end
    end else begin
      r.relay_on  = default_q;
      r.remaining = -32'sd1;
    end

    r.shown = r.relay_on;
    for (k = 0; k < pend_cnt; k++) if (pend_tbl[k].timed) r.shown = pend_tbl[k].state;
    return r;
  endfunction

  // one command transaction, with an optional idle burst ahead of it
  task automatic send_cmd(input relay_cmd_t c, input logic fixed, input relay_status_t st);
    relay_status_t pred;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.action       <= c.action;
    cmd_if.command_id   <= c.id;
    cmd_if.wanted_state <= c.wanted;
    cmd_if.duration_ms  <= c.dur;
    cmd_if.now_ms       <= c.now;
    do @(posedge clk_i); while (!cmd_if.ready);
    pred = predict_relay_status(c);
    status_q.insert(status_q.size(), fixed ? st : pred);
  endtask

  // hold the sender until every status has come back
  task automatic await_drain();
    cmd_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  // register writes, valid stays high between the two
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDatW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_MARGIN) begin
      margin_q = d;
    end else begin
      default_q = d[0];
    end
  endtask

  task automatic write_config(input logic [MarginW-1:0] margin, input logic pwr);
    write_reg(CFG_MARGIN, margin);
    write_reg(CFG_POWER_ON, {(CfgDatW-1)'($urandom), pwr});
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [CmdIdW-1:0] pick_id();
    if ($urandom_range(0, 9) < 7) return id_pool[$urandom_range(0, 3)];
    return CmdIdW'($urandom);
  endfunction

  // random command, mostly well-formed traffic on a rising clock
  task automatic gen_cmd(output relay_cmd_t c);
    int sel;
    int t;
    sel      = $urandom_range(0, 99);
    c.wanted = 1'($urandom_range(0, 1));
    c.dur    = DurW'($urandom);
    c.id     = pick_id();
    if (sel < 30) begin
      c.action = ACT_TIMED;
      case ($urandom_range(0, 5))
        0: begin
          t = int'(margin_q) + int'($urandom_range(0, 4)) - 2;
          c.dur = (t < 0) ? '0 : DurW'(t);
        end
        1, 2: c.dur = DurW'($urandom_range(0, 20000));
        3:    c.dur = DurW'($urandom_range(0, 200000));
        4:    c.dur = DurW'($urandom);
        default: c.dur = '1;
      endcase
    end else if (sel < 45) begin
      c.action = ACT_DEFAULT;
    end else if (sel < 82) begin
      c.action = (sel < 70) ? ACT_SUCCESS : ACT_FAILURE;
      if (pend_cnt > 0 && $urandom_range(0, 9) < 8)
        c.id = pend_tbl[$urandom_range(0, pend_cnt - 1)].id;
    end else if (sel < 95) begin
      c.action = ACT_POLL;
    end else begin
      c.action = ActUnknown - ActW'($urandom_range(0, 2));
    end
    // timestamps: steady steps, rare jumps, rare looks into the past
    case ($urandom_range(0, 39))
      0: wall_ms = TimeW'({$urandom, $urandom});
      1: wall_ms = '1 - TimeW'($urandom_range(0, 20000));
      default: wall_ms = wall_ms + TimeW'($urandom_range(0, 3000));
    endcase
    c.now = wall_ms;
    if ($urandom_range(0, 39) == 0) c.now = wall_ms - TimeW'($urandom_range(0, 5000));
  endtask

  // stimulus
  initial begin : stim
    relay_cmd_t      c;
    logic [MarginW-1:0] margin;
    logic            pwr;
    rst_ni              = 1'b0;
    clk_i               = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.action       = ACT_POLL;
    cmd_if.command_id   = '0;
    cmd_if.wanted_state = 1'b0;
    cmd_if.duration_ms  = '0;
    cmd_if.now_ms       = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_MARGIN;
    cfg_if.data         = '0;

    cmd_tbl = '{
      '{'{ACT_POLL,    16'h0000, 1'b0, 31'h0,        48'h0},              1'b1,
        '{1'b0, 1'b0, -32'sd1, 1'b0, 1'b0}},
      '{'{ActUnknown,  16'hFFFF, 1'b1, 31'h7FFFFFFF, 48'hFFFF_FFFF_FFFF}, 1'b1,
        '{1'b0, 1'b0, -32'sd1, 1'b0, 1'b0}},
      '{'{ACT_SUCCESS, 16'hFFFF, 1'b0, 31'h0,        48'd10},             1'b1,
        '{1'b0, 1'b0, -32'sd1, 1'b0, 1'b0}},
      '{'{ACT_FAILURE, 16'hFFFF, 1'b1, 31'h0,        48'd20},             1'b1,
        '{1'b0, 1'b0, -32'sd1, 1'b0, 1'b0}},
      '{'{ACT_TIMED,   16'h0001, 1'b1, 31'h7FFFFFFF, 48'd100},            1'b1,
        '{1'b0, 1'b1, -32'sd1, 1'b0, 1'b0}},
      '{'{ACT_DEFAULT, 16'h0002, 1'b1, 31'h7FFFFFFF, 48'd110},            1'b0, '0},
      '{'{ACT_TIMED,   16'h0003, 1'b1, 31'd3000,     48'd120},            1'b0, '0},
      '{'{ACT_TIMED,   16'h0003, 1'b0, 31'd3001,     48'd130},            1'b0, '0},
      '{'{ACT_DEFAULT, 16'h0004, 1'b0, 31'h0,        48'd140},            1'b0, '0},
      '{'{ACT_TIMED,   16'h0005, 1'b1, 31'h0,        48'd150},            1'b0, '0},
      '{'{ACT_TIMED,   16'h0006, 1'b0, 31'd10000,    48'd160},            1'b0, '0},
      '{'{ACT_TIMED,   16'hFFFF, 1'b1, 31'd5000,     48'd170},            1'b0, '0},
      // table full, command dropped
      '{'{ACT_TIMED,   16'h0007, 1'b0, 31'd1,        48'd180},            1'b1,
        '{1'b0, 1'b1, -32'sd1, 1'b0, 1'b1}},
      '{'{ACT_SUCCESS, 16'h0002, 1'b0, 31'h0,        48'd200},            1'b0, '0},
      '{'{ACT_SUCCESS, 16'h0001, 1'b0, 31'h0,        48'd1000},           1'b0, '0},
      // clock behind the override start
      '{'{ACT_POLL,    16'h0000, 1'b0, 31'h0,        48'd0},              1'b0, '0},
      // duration equal to the margin gives no override
      '{'{ACT_SUCCESS, 16'h0003, 1'b0, 31'h0,        48'd2000},           1'b0, '0},
      '{'{ACT_TIMED,   16'h0006, 1'b1, 31'd20,       48'd2050},           1'b0, '0},
      '{'{ACT_FAILURE, 16'h0006, 1'b0, 31'h0,        48'd2100},           1'b0, '0},
      '{'{ACT_SUCCESS, 16'h0003, 1'b0, 31'h0,        48'd2200},           1'b0, '0},
      '{'{ACT_POLL,    16'h0000, 1'b0, 31'h0,        48'd2201},           1'b0, '0},
      // override just over
      '{'{ACT_POLL,    16'h0000, 1'b0, 31'h0,        48'd2202},           1'b0, '0},
      '{'{ACT_SUCCESS, 16'h0004, 1'b0, 31'h0,        48'd2300},           1'b0, '0},
      '{'{ACT_FAILURE, 16'h0005, 1'b0, 31'h0,        48'd2400},           1'b0, '0},
      '{'{ACT_SUCCESS, 16'hFFFF, 1'b0, 31'h0,        48'hFFFF_FFFF_FFFF}, 1'b0, '0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset settings
    foreach (cmd_tbl[i]) send_cmd(cmd_tbl[i].cmd, cmd_tbl[i].fixed, cmd_tbl[i].status);

    // random phases, each under its own register settings
    for (int p = 0; p < NumPhases; p++) begin
      await_drain();
      case (p)
        0: begin margin = '0; pwr = 1'b1; end
        1: begin margin = '1; pwr = 1'b0; end
        2: begin margin = 16'd1; pwr = 1'b1; end
        default: begin margin = MarginW'($urandom); pwr = 1'($urandom_range(0, 1)); end
      endcase
      write_config(margin, pwr);
      idle_on = (p != NumPhases - 1);
      foreach (id_pool[k]) id_pool[k] = CmdIdW'($urandom);
      wall_ms = TimeW'($urandom_range(0, 100000));
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == 1 && n == 100) hold_len = HoldCycles;
        if (p == 2 && n == 150) await_drain();
        gen_cmd(c);
        send_cmd(c, 1'b0, '0);
      end
    end

    await_drain();
    repeat (30) @(posedge clk_i);
    if (status_q.size() != 0) report_mismatch("status still outstanding at end of run");
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side: check each transaction, stall in random bursts
  initial begin : sink
    relay_status_t want;
    int            stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("status transaction with none outstanding");
        end else begin
          want = status_q.pop_front();
          if (res_if.relay_on !== want.relay_on)
            report_mismatch($sformatf("relay_on got %0d expected %0d",
                                      res_if.relay_on, want.relay_on));
          if (res_if.shown_request !== want.shown)
            report_mismatch($sformatf("shown_request got %0d expected %0d",
                                      res_if.shown_request, want.shown));
          if (res_if.remaining_ms !== want.remaining)
            report_mismatch($sformatf("remaining_ms got %0d expected %0d",
                                      res_if.remaining_ms, want.remaining));
          if (res_if.matched !== want.matched)
            report_mismatch($sformatf("matched got %0d expected %0d",
                                      res_if.matched, want.matched));
          if (res_if.queue_full !== want.full)
            report_mismatch($sformatf("queue_full got %0d expected %0d",
                                      res_if.queue_full, want.full));
        end
      end
      // long hold-off on request, short random bursts otherwise
      if (hold_len > 0) begin
        stall_left = hold_len;
        hold_len   = 0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
